FILE: sv/cvam_pkg.sv
package cvam_pkg;

  localparam int CHANNELS     = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CH_W         = 3;
  localparam int OUT_W        = 17;
  localparam int SUM_W        = 19;
  localparam int CNT_W        = 4;
  localparam int KNOB_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 64;
  localparam int GAIN_W       = 17;
  localparam int OFF_W        = 18;
  localparam int MUL_W        = 18;
  localparam int PROD1_W      = 32;
  localparam int PROD2_W      = 2 * MUL_W;
  localparam int GQ_W         = 16;
  localparam int FIN_W        = 22;
  localparam int DIVD_W       = 20;
  localparam int DCNT_W       = 5;

  localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic signed [SAMPLE_WIDTH-1:0] VLIM_POS = 16'sd20480;
  localparam logic signed [SAMPLE_WIDTH-1:0] VLIM_NEG = -16'sd20480;
  localparam logic signed [FIN_W-1:0] VLIM_POS_W = 22'sd20480;
  localparam logic signed [FIN_W-1:0] VLIM_NEG_W = -22'sd20480;
  localparam logic signed [SUM_W:0] SUM_MAX_W = 20'sd262143;
  localparam logic signed [SUM_W:0] SUM_MIN_W = -20'sd262144;

  // floor(x / 5) as (x * RECIP5) >> 20, exact for x below 2**18
  localparam logic [MUL_W-1:0] RECIP5     = 18'd209716;
  localparam int               RECIP5_SH  = 20;
  localparam int               VLIM_SH    = 12;
  localparam int               GAIN_SH    = 14;
  localparam logic [PROD2_W-1:0] GAIN_RND = PROD2_W'((1 << GAIN_SH) - 1);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE  = 3'd4;

  typedef struct packed {
    logic load_in;
    logic gmul;
    logic gdiv;
    logic gsel;
    logic mul;
    logic fin;
    logic div_start;
    logic div_step;
    logic out_load;
  } cvam_cmd_t;

  typedef struct packed {
    logic last;
    logic count_zero;
    logic div_done;
    logic out_free;
  } cvam_sts_t;

endpackage

FILE: sv/cvam_in_if.sv
interface cvam_in_if import cvam_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [CH_W-1:0]                channel;
  logic signed [SAMPLE_WIDTH-1:0] signal_in;
  logic signed [SAMPLE_WIDTH-1:0] gain_cv;
  logic signed [SAMPLE_WIDTH-1:0] offset_cv;
  logic                           signal_present;
  logic                           gain_cv_present;
  logic                           offset_cv_present;
  logic                           output_in_use;

  modport source (output valid, channel, signal_in, gain_cv, offset_cv, signal_present,
                  gain_cv_present, offset_cv_present, output_in_use, input ready);
  modport sink (input valid, channel, signal_in, gain_cv, offset_cv, signal_present,
                gain_cv_present, offset_cv_present, output_in_use, output ready);
endinterface

FILE: sv/cvam_out_if.sv
interface cvam_out_if import cvam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel_number;
  logic signed [OUT_W-1:0] channel_out;
  logic                    channel_driven;
  logic signed [OUT_W-1:0] mix_out;
  logic                    mix_valid;

  modport source (output valid, channel_number, channel_out, channel_driven, mix_out,
                  mix_valid, input ready);
  modport sink (input valid, channel_number, channel_out, channel_driven, mix_out,
                mix_valid, output ready);
endinterface

FILE: sv/cvam_cfg_if.sv
interface cvam_cfg_if import cvam_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/cvam_ctrl.sv
module cvam_ctrl import cvam_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cvam_sts_t sts,
  output cvam_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GMUL = 3'd1;
  localparam logic [2:0] ST_GDIV = 3'd2;
  localparam logic [2:0] ST_GSEL = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_GMUL;
        end
      end
      ST_GMUL: begin
        cmd.gmul  = 1'b1;
        state_nxt = ST_GDIV;
      end
      ST_GDIV: begin
        cmd.gdiv  = 1'b1;
        state_nxt = ST_GSEL;
      end
      ST_GSEL: begin
        cmd.gsel  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin       = 1'b1;
        cmd.div_start = sts.last;
        if (sts.last && !sts.count_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/cvam_dp.sv
module cvam_dp import cvam_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cvam_cmd_t                      cmd,
  output cvam_sts_t                      sts,
  input  logic [CH_W-1:0]                in_channel,
  input  logic signed [SAMPLE_WIDTH-1:0] in_signal_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_gain_cv,
  input  logic signed [SAMPLE_WIDTH-1:0] in_offset_cv,
  input  logic                           in_signal_present,
  input  logic                           in_gain_cv_present,
  input  logic                           in_offset_cv_present,
  input  logic                           in_output_in_use,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [CH_W-1:0]                out_channel_number,
  output logic signed [OUT_W-1:0]        out_channel_out,
  output logic                           out_channel_driven,
  output logic signed [OUT_W-1:0]        out_mix_out,
  output logic                           out_mix_valid
);

  // configuration
  logic [CFG_W-1:0] gain_lo_r, gain_hi_r, off_lo_r, off_hi_r;
  logic             double_r;

  // item registers
  logic [CH_W-1:0]                ch_r;
  logic signed [SAMPLE_WIDTH-1:0] sig_r, gcv_r, ocv_r;
  logic                           sig_p_r, gcv_p_r, ocv_p_r, used_r;
  logic signed [KNOB_W-1:0]       gk_r;
  logic signed [PROD1_W-1:0]      prod1_r;
  logic signed [OFF_W-1:0]        off_r;
  logic [GQ_W-1:0]                gq_r;
  logic                           gneg_r;
  logic signed [GAIN_W-1:0]       gain_r;
  logic signed [PROD2_W-1:0]      prod2_r;
  logic signed [OUT_W-1:0]        res_chan_r;
  logic                           res_driven_r;

  // accumulators
  logic signed [SUM_W-1:0] mix_sum_r;
  logic [CNT_W-1:0]        cnt_r;

  // mix divider
  logic [DIVD_W-1:0] quot_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvsr_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              mneg_r;

  // output word
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [OUT_W-1:0] out_chan_r;
  logic                    out_driven_r;
  logic signed [OUT_W-1:0] out_mix_r;
  logic                    out_mixv_r;

  logic [CFG_W-1:0]               gsel_reg, osel_reg;
  logic signed [KNOB_W-1:0]       gk_sel, ok_sel;
  logic signed [SAMPLE_WIDTH-1:0] gcv_cl, ocv_cl;
  logic [PROD1_W-1:0]             p1_mag;
  logic [MUL_W-1:0]               p1_sh;
  logic [PROD2_W-1:0]             q5_full;
  logic signed [MUL_W-1:0]        mul_a, mul_b;
  logic signed [FIN_W-1:0]        tq, ysum, y;
  logic signed [SUM_W:0]          sum_add, sum_new, sum_od;
  logic [CNT_W-1:0]               cnt_new;
  logic signed [OUT_W-1:0]        chan_val;
  logic [DIVD_W-1:0]              mix_mag;
  logic [CNT_W:0]                 rem_sh;
  logic                           qbit;
  logic signed [DIVD_W:0]         mix_signed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_lo_r <= '0;
      gain_hi_r <= '0;
      off_lo_r  <= '0;
      off_hi_r  <= '0;
      double_r  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_LO: gain_lo_r <= cfg_data;
        REG_GAIN_HI: gain_hi_r <= cfg_data;
        REG_OFF_LO:  off_lo_r  <= cfg_data;
        REG_OFF_HI:  off_hi_r  <= cfg_data;
        REG_DOUBLE:  double_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gcv_cl = in_gain_cv;
    if (in_gain_cv > VLIM_POS) gcv_cl = VLIM_POS;
    if (in_gain_cv < VLIM_NEG) gcv_cl = VLIM_NEG;
    ocv_cl = in_offset_cv;
    if (in_offset_cv > VLIM_POS) ocv_cl = VLIM_POS;
    if (in_offset_cv < VLIM_NEG) ocv_cl = VLIM_NEG;
  end

  always_comb begin
    gsel_reg = ch_r[2] ? gain_hi_r : gain_lo_r;
    osel_reg = ch_r[2] ? off_hi_r : off_lo_r;
    gk_sel   = gsel_reg[KNOB_W*ch_r[1:0] +: KNOB_W];
    ok_sel   = osel_reg[KNOB_W*ch_r[1:0] +: KNOB_W];
  end

  // gain cv divide by 20480: drop 12 bits then divide by five
  always_comb begin
    p1_mag  = prod1_r[PROD1_W-1] ? PROD1_W'(-prod1_r) : PROD1_W'(prod1_r);
    p1_sh   = p1_mag[VLIM_SH +: MUL_W];
    q5_full = PROD2_W'(p1_sh) * PROD2_W'(RECIP5);
  end

  always_comb begin
    mul_a = sig_p_r ? MUL_W'(sig_r) : MUL_W'(off_r);
    mul_b = MUL_W'(gain_r);
  end

  always_comb begin
    tq      = FIN_W'((prod2_r + (prod2_r[PROD2_W-1] ? $signed(GAIN_RND) : '0)) >>> GAIN_SH);
    ysum    = tq + (sig_p_r ? FIN_W'(off_r) : '0);
    y       = ysum;
    if (ysum > VLIM_POS_W) y = VLIM_POS_W;
    if (ysum < VLIM_NEG_W) y = VLIM_NEG_W;
    sum_add = (SUM_W+1)'(mix_sum_r) + (SUM_W+1)'(y);
    sum_new = (SUM_W+1)'(mix_sum_r);
    cnt_new = cnt_r;
    if (sig_p_r) begin
      sum_new = sum_add;
      if (sum_add > SUM_MAX_W) sum_new = SUM_MAX_W;
      if (sum_add < SUM_MIN_W) sum_new = SUM_MIN_W;
      if (cnt_r != COUNT_MAX) cnt_new = cnt_r + 1'b1;
    end
    sum_od   = double_r ? (sum_new <<< 1) : sum_new;
    mix_mag  = sum_od[SUM_W] ? DIVD_W'(-sum_od) : DIVD_W'(sum_od);
    chan_val = '0;
    if (sig_p_r || used_r) begin
      chan_val = double_r ? (OUT_W'(y) <<< 1) : OUT_W'(y);
    end
  end

  always_comb begin
    rem_sh     = {rem_r, quot_r[DIVD_W-1]};
    qbit       = rem_sh >= {1'b0, dvsr_r};
    mix_signed = mneg_r ? -(DIVD_W+1)'(quot_r) : (DIVD_W+1)'(quot_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r    <= in_channel;
      sig_r   <= in_signal_in;
      gcv_r   <= gcv_cl;
      ocv_r   <= ocv_cl;
      sig_p_r <= in_signal_present;
      gcv_p_r <= in_gain_cv_present;
      ocv_p_r <= in_offset_cv_present;
      used_r  <= in_output_in_use;
    end
    if (cmd.gmul) begin
      gk_r    <= gk_sel;
      prod1_r <= gcv_r * gk_sel;
      off_r   <= OFF_W'(ok_sel) + (ocv_p_r ? OFF_W'(ocv_r) : '0);
    end
    if (cmd.gdiv) begin
      gq_r   <= q5_full[RECIP5_SH +: GQ_W];
      gneg_r <= prod1_r[PROD1_W-1];
    end
    if (cmd.gsel) begin
      if (gcv_p_r) begin
        gain_r <= gneg_r ? -GAIN_W'(gq_r) : GAIN_W'(gq_r);
      end else begin
        gain_r <= GAIN_W'(gk_r);
      end
    end
    if (cmd.mul) begin
      prod2_r <= mul_a * mul_b;
    end
    if (cmd.fin) begin
      res_chan_r   <= chan_val;
      res_driven_r <= sig_p_r || used_r;
    end
    if (cmd.div_start) begin
      quot_r <= (cnt_new == '0) ? '0 : mix_mag;
      rem_r  <= '0;
      dvsr_r <= cnt_new;
      dcnt_r <= '0;
      mneg_r <= sum_od[SUM_W];
    end else if (cmd.div_step) begin
      rem_r  <= qbit ? CNT_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[CNT_W-1:0];
      quot_r <= {quot_r[DIVD_W-2:0], qbit};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_ch_r     <= ch_r;
      out_chan_r   <= res_chan_r;
      out_driven_r <= res_driven_r;
      out_mixv_r   <= ch_r == LAST_CH;
      out_mix_r    <= (ch_r == LAST_CH) ? OUT_W'(mix_signed) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_sum_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        if (ch_r == LAST_CH) begin
          mix_sum_r <= '0;
          cnt_r     <= '0;
        end else begin
          mix_sum_r <= SUM_W'(sum_new);
          cnt_r     <= cnt_new;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.last       = ch_r == LAST_CH;
  assign sts.count_zero = cnt_new == '0;
  assign sts.div_done   = dcnt_r == DCNT_W'(DIVD_W - 1);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_channel_number = out_ch_r;
  assign out_channel_out    = out_chan_r;
  assign out_channel_driven = out_driven_r;
  assign out_mix_out        = out_mix_r;
  assign out_mix_valid      = out_mixv_r;

endmodule

FILE: sv/cv_attenuverter_offset_mixer.sv
// order: an accepted word steps through gain multiply, gain divide, gain select,
// multiply and finish, then the serial mix divider (one quotient bit per cycle) on
// the last channel of a frame when a signal was present, then the output load,
// which waits while the output word is stalled; a new word is taken only after that
// reset: knobs, overdrive, mix sum, count and output valid clear; no clearing pass
module cv_attenuverter_offset_mixer import cvam_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cvam_in_if.sink    in_bus,
  cvam_out_if.source out_bus,
  cvam_cfg_if.sink   cfg_bus
);

  cvam_cmd_t cmd;
  cvam_sts_t sts;
  logic      in_ready;

  assign in_bus.ready  = in_ready;
  assign cfg_bus.ready = 1'b1;

  cvam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cvam_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_channel           (in_bus.channel),
    .in_signal_in         (in_bus.signal_in),
    .in_gain_cv           (in_bus.gain_cv),
    .in_offset_cv         (in_bus.offset_cv),
    .in_signal_present    (in_bus.signal_present),
    .in_gain_cv_present   (in_bus.gain_cv_present),
    .in_offset_cv_present (in_bus.offset_cv_present),
    .in_output_in_use     (in_bus.output_in_use),
    .cfg_write            (cfg_bus.valid),
    .cfg_index            (cfg_bus.index),
    .cfg_data             (cfg_bus.data),
    .out_ready            (out_bus.ready),
    .out_valid            (out_bus.valid),
    .out_channel_number   (out_bus.channel_number),
    .out_channel_out      (out_bus.channel_out),
    .out_channel_driven   (out_bus.channel_driven),
    .out_mix_out          (out_bus.mix_out),
    .out_mix_valid        (out_bus.mix_valid)
  );

endmodule

FILE: sv/cvam_checker.sv
module cvam_checker import cvam_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CH_W-1:0]         out_channel_number,
  input logic signed [OUT_W-1:0] out_channel_out,
  input logic                    out_channel_driven,
  input logic signed [OUT_W-1:0] out_mix_out,
  input logic                    out_mix_valid
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_number)
      && $stable(out_channel_out) && $stable(out_mix_out))
    else $error("stalled output word changed");

  a_mix_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mix_valid == (out_channel_number == LAST_CH))
    else $error("mix flag not tied to last channel");

  a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_channel_driven |-> out_channel_out == '0)
    else $error("undriven channel has nonzero output");

  a_mix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mix_valid |-> out_mix_out == '0)
    else $error("mix output nonzero off the last channel");

endmodule

bind cv_attenuverter_offset_mixer cvam_checker u_cvam_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_channel_number (out_bus.channel_number),
  .out_channel_out    (out_bus.channel_out),
  .out_channel_driven (out_bus.channel_driven),
  .out_mix_out        (out_bus.mix_out),
  .out_mix_valid      (out_bus.mix_valid)
);

FILE: tb/cvam_mix_checker.sv
module cvam_mix_checker import cvam_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cvam_in_if   in_bus,
  cvam_out_if  out_bus,
  cvam_cfg_if  cfg_bus,
  output int   fail_count,
  output int   pending
);

  localparam longint VOLT_LIM   = VLIM_POS;
  localparam longint UNITY_GAIN = longint'(1) << GAIN_SH;
  localparam longint SUM_HI     = SUM_MAX_W;
  localparam longint SUM_LO     = SUM_MIN_W;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic signed [OUT_W-1:0] chan_out;
    logic                    driven;
    logic signed [OUT_W-1:0] mix;
    logic                    mix_valid;
  } chan_result_t;

  logic [CFG_W-1:0]        gain_knobs_lo;
  logic [CFG_W-1:0]        gain_knobs_hi;
  logic [CFG_W-1:0]        off_knobs_lo;
  logic [CFG_W-1:0]        off_knobs_hi;
  logic                    double_out;
  logic signed [SUM_W-1:0] mix_acc;
  logic [CNT_W-1:0]        present_cnt;
  chan_result_t            chan_results_q[$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint knob_of(input logic [CFG_W-1:0] lo_reg,
                                     input logic [CFG_W-1:0] hi_reg,
                                     input logic [CH_W-1:0] ch);
    logic [CFG_W-1:0]         sel;
    logic signed [KNOB_W-1:0] k;
    sel = ch[2] ? hi_reg : lo_reg;
    k = sel[ch[1:0]*KNOB_W +: KNOB_W];
    return longint'(k);
  endfunction

  task automatic attenuvert_word(input logic [CH_W-1:0] ch,
                                 input logic signed [SAMPLE_WIDTH-1:0] sig_v,
                                 input logic signed [SAMPLE_WIDTH-1:0] gcv_v,
                                 input logic signed [SAMPLE_WIDTH-1:0] ocv_v,
                                 input logic sig_p, input logic gcv_p,
                                 input logic ocv_p, input logic used);
    longint       gk, ok, gcv, ocv, gain, off, y, od, mix;
    chan_result_t r;
    od = double_out ? 2 : 1;
    gk = knob_of(gain_knobs_lo, gain_knobs_hi, ch);
    ok = knob_of(off_knobs_lo, off_knobs_hi, ch);
    gcv = clamp(longint'(gcv_v), -VOLT_LIM, VOLT_LIM);
    ocv = clamp(longint'(ocv_v), -VOLT_LIM, VOLT_LIM);
    gain = gcv_p ? (gcv * gk) / VOLT_LIM : gk;
    off = ocv_p ? ok + ocv : ok;
    if (sig_p) begin
      y = clamp((longint'(sig_v) * gain) / UNITY_GAIN + off, -VOLT_LIM, VOLT_LIM);
      mix_acc = SUM_W'(clamp(longint'(mix_acc) + y, SUM_LO, SUM_HI));
      if (present_cnt != COUNT_MAX) present_cnt = present_cnt + 1'b1;
    end else begin
      y = clamp((gain * off) / UNITY_GAIN, -VOLT_LIM, VOLT_LIM);
    end
    mix = 0;
    if (ch == LAST_CH) begin
      if (present_cnt != '0) mix = (longint'(mix_acc) * od) / longint'(present_cnt);
      mix_acc = '0;
      present_cnt = '0;
    end
    r.ch = ch;
    r.driven = sig_p || used;
    r.chan_out = r.driven ? OUT_W'(y * od) : '0;
    r.mix = OUT_W'(mix);
    r.mix_valid = (ch == LAST_CH);
    chan_results_q.push_back(r);
  endtask

  task automatic check_result();
    chan_result_t exp_r;
    if (chan_results_q.size() == 0) begin
      $error("unexpected result word for channel %0d", out_bus.channel_number);
      fail_count++;
    end else begin
      exp_r = chan_results_q.pop_front();
      if (out_bus.channel_number !== exp_r.ch) begin
        $error("channel_number: expected %0d, got %0d", exp_r.ch, out_bus.channel_number);
        fail_count++;
      end
      if (out_bus.channel_out !== exp_r.chan_out) begin
        $error("channel_out: expected %0d, got %0d", exp_r.chan_out, out_bus.channel_out);
        fail_count++;
      end
      if (out_bus.channel_driven !== exp_r.driven) begin
        $error("channel_driven: expected %0d, got %0d", exp_r.driven, out_bus.channel_driven);
        fail_count++;
      end
      if (out_bus.mix_out !== exp_r.mix) begin
        $error("mix_out: expected %0d, got %0d", exp_r.mix, out_bus.mix_out);
        fail_count++;
      end
      if (out_bus.mix_valid !== exp_r.mix_valid) begin
        $error("mix_valid: expected %0d, got %0d", exp_r.mix_valid, out_bus.mix_valid);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_knobs_lo = '0;
      gain_knobs_hi = '0;
      off_knobs_lo = '0;
      off_knobs_hi = '0;
      double_out = 1'b0;
      mix_acc = '0;
      present_cnt = '0;
      chan_results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_GAIN_LO: gain_knobs_lo = cfg_bus.data;
          REG_GAIN_HI: gain_knobs_hi = cfg_bus.data;
          REG_OFF_LO:  off_knobs_lo = cfg_bus.data;
          REG_OFF_HI:  off_knobs_hi = cfg_bus.data;
          REG_DOUBLE:  double_out = cfg_bus.data[0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) check_result();
      if (in_bus.valid && in_bus.ready) begin
        attenuvert_word(in_bus.channel, in_bus.signal_in, in_bus.gain_cv, in_bus.offset_cv,
                        in_bus.signal_present, in_bus.gain_cv_present,
                        in_bus.offset_cv_present, in_bus.output_in_use);
      end
    end
    pending = chan_results_q.size();
  end

endmodule

FILE: tb/cv_attenuverter_offset_mixer_test.sv
module cv_attenuverter_offset_mixer_test;
  import cvam_pkg::*;

  localparam int RUN_LIMIT     = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 240;

  typedef struct packed {
    logic [CH_W-1:0]                ch;
    logic signed [SAMPLE_WIDTH-1:0] sig;
    logic signed [SAMPLE_WIDTH-1:0] gcv;
    logic signed [SAMPLE_WIDTH-1:0] ocv;
    logic                           sig_p;
    logic                           gcv_p;
    logic                           ocv_p;
    logic                           used;
  } chan_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;

  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          stall_level = 1;
  int          bits_age = 0;
  logic [31:0] ready_bits = '1;

  cvam_in_if  in_bus();
  cvam_out_if out_bus();
  cvam_cfg_if cfg_bus();

  cv_attenuverter_offset_mixer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  cvam_mix_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_bus    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (bits_age == 0) begin
      bits_age = 32;
      case (stall_level)
        1:       ready_bits = $urandom | $urandom;
        2:       ready_bits = $urandom;
        default: ready_bits = $urandom & $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) ready_bits = '1;
    end
    bits_age--;
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= (stall_level == 0) || ready_bits[0];
    end
    ready_bits = {ready_bits[0], ready_bits[31:1]};
  end

  function automatic chan_word_t make_word(input logic [CH_W-1:0] ch,
                                           input logic [SAMPLE_WIDTH-1:0] sig,
                                           input logic [SAMPLE_WIDTH-1:0] gcv,
                                           input logic [SAMPLE_WIDTH-1:0] ocv,
                                           input logic [3:0] flags);
    chan_word_t w;
    w.ch = ch;
    w.sig = sig;
    w.gcv = gcv;
    w.ocv = ocv;
    {w.sig_p, w.gcv_p, w.ocv_p, w.used} = flags;
    return w;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_volt();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_WIDTH'(20479 + $urandom_range(0, 2));
      3:       return SAMPLE_WIDTH'(-20481 + int'($urandom_range(0, 2)));
      4:       return '0;
      5, 6:    return SAMPLE_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic chan_word_t rand_word(input logic [CH_W-1:0] ch);
    chan_word_t w;
    w.ch = ch;
    w.sig = pick_volt();
    w.gcv = pick_volt();
    w.ocv = pick_volt();
    w.sig_p = ($urandom_range(0, 3) != 0);
    w.gcv_p = 1'($urandom_range(0, 1));
    w.ocv_p = 1'($urandom_range(0, 1));
    w.used = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] rand_knobs(input bit volts);
    logic [CFG_W-1:0] r;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0:       r[i*KNOB_W +: KNOB_W] = 16'h7FFF;
        1:       r[i*KNOB_W +: KNOB_W] = 16'h8000;
        2:       r[i*KNOB_W +: KNOB_W] = '0;
        default: r[i*KNOB_W +: KNOB_W] = volts ? KNOB_W'(int'($urandom_range(0, 20480)) - 10240)
                                                : KNOB_W'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic push_word(input chan_word_t w);
    in_bus.valid <= 1'b1;
    in_bus.channel <= w.ch;
    in_bus.signal_in <= w.sig;
    in_bus.gain_cv <= w.gcv;
    in_bus.offset_cv <= w.ocv;
    in_bus.signal_present <= w.sig_p;
    in_bus.gain_cv_present <= w.gcv_p;
    in_bus.offset_cv_present <= w.ocv_p;
    in_bus.output_in_use <= w.used;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] g_lo, input logic [CFG_W-1:0] g_hi,
                              input logic [CFG_W-1:0] o_lo, input logic [CFG_W-1:0] o_hi,
                              input logic dbl);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_GAIN_LO, g_lo);
    write_reg(REG_GAIN_HI, g_hi);
    write_reg(REG_OFF_LO, o_lo);
    write_reg(REG_OFF_HI, o_hi);
    write_reg(REG_DOUBLE, CFG_W'(dbl));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_words, input int gap_max, input bit long_hold,
                           input bit sync_pause, input int skip_pct);
    int              sent;
    int              burst_left;
    int              gap;
    logic [CH_W-1:0] next_ch;
    logic [CH_W-1:0] ch;
    sent = 0;
    next_ch = '0;
    burst_left = $urandom_range(1, 40);
    while (sent < n_words) begin
      // mostly frames in order, some dropped last channels and stray words
      if (next_ch == LAST_CH && $urandom_range(0, 99) < skip_pct) ch = '0;
      else if ($urandom_range(0, 39) == 0) ch = CH_W'($urandom_range(0, CHANNELS - 1));
      else ch = next_ch;
      next_ch = ch + 1'b1;
      push_word(rand_word(ch));
      sent++;
      burst_left--;
      if (long_hold && sent == n_words / 3) hold_requests++;
      if (sync_pause && sent == 2 * n_words / 3) begin
        wait_results();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.signal_in = '0;
    in_bus.gain_cv = '0;
    in_bus.offset_cv = '0;
    in_bus.signal_present = 1'b0;
    in_bus.gain_cv_present = 1'b0;
    in_bus.offset_cv_present = 1'b0;
    in_bus.output_in_use = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_setting(64'hC000_8000_7FFF_4000, 64'h4000_4000_2000_4000,
                 64'h7FFF_D800_2800_0000, 64'h0000_0000_0400_8000, 1'b0);
    // one frame through the corners of each path
    push_word(make_word(3'd0, 16'h7FFF, 16'h0000, 16'h0000, 4'b1001));
    push_word(make_word(3'd1, 16'h8000, 16'h8000, 16'h7FFF, 4'b1111));
    push_word(make_word(3'd2, 16'h0000, 16'h7FFF, 16'h8000, 4'b0111));
    push_word(make_word(3'd3, 16'h1000, 16'h0000, 16'h0000, 4'b1000));
    push_word(make_word(3'd4, 16'h0000, 16'h0000, 16'h0000, 4'b0000));
    push_word(make_word(3'd5, 16'h5000, 16'hB000, 16'h5001, 4'b1111));
    push_word(make_word(3'd6, 16'hAFFF, 16'h5001, 16'hAFFF, 4'b0110));
    push_word(make_word(3'd7, 16'h0800, 16'h0000, 16'h0000, 4'b1001));
    // sum and count saturation without a last channel
    for (int i = 0; i < 16; i++) begin
      push_word(make_word(CH_W'(i % 2), 16'h7FFF, 16'h0000, 16'h0000, 4'b1001));
    end
    push_word(make_word(LAST_CH, 16'h7FFF, 16'h0000, 16'h0000, 4'b1001));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_setting({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b1);
        1: load_setting({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 1'b0);
        4: load_setting('0, '0, '0, '0, 1'b0);
        default: load_setting(rand_knobs(1'b0), rand_knobs(1'b0), rand_knobs(1'b1),
                              rand_knobs(1'b1), 1'($urandom_range(0, 1)));
      endcase
      stall_level = p % 4;
      run_phase(PHASE_WORDS, (p * 5) % 13, p == 2, p == 3 || p == 6, (p == 5) ? 40 : 5);
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
